// ----- src/timed_sample_derivative_assert.svh -----
// Assertion macros shared by the timed sample derivative RTL.
`ifndef TIMED_SAMPLE_DERIVATIVE_ASSERT_SVH
`define TIMED_SAMPLE_DERIVATIVE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define TSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define TSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tsd_pkg.sv -----
// Shared widths and defaults for the timed sample derivative.
`default_nettype none

package tsd_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOPE_W = 32;
  localparam int unsigned SPAN_W  = 31;

  localparam int unsigned   SLOPE_SCALE_DEF = 1024;
  localparam logic [30:0]   MIN_SPAN_RST    = 31'd1;

endpackage

`default_nettype wire

// ----- src/tsd_in_if.sv -----
// Input channel carrying one timestamped sample per beat.
`default_nettype none

interface tsd_in_if;

  logic                            valid;
  logic                            ready;
  logic [tsd_pkg::VAL_W-1:0]       sample_value;
  logic [tsd_pkg::STAMP_W-1:0]     sample_stamp;

  modport source (output valid, output sample_value, output sample_stamp, input ready);
  modport sink   (input valid, input sample_value, input sample_stamp, output ready);

endinterface

`default_nettype wire

// ----- src/tsd_out_if.sv -----
// Result channel carrying one slope and its refresh flag per beat.
`default_nettype none

interface tsd_out_if;

  logic                               valid;
  logic                               ready;
  logic signed [tsd_pkg::SLOPE_W-1:0] slope;
  logic                               refreshed;

  modport source (output valid, output slope, output refreshed, input ready);
  modport sink   (input valid, input slope, input refreshed, output ready);

endinterface

`default_nettype wire

// ----- src/tsd_div.sv -----
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module tsd_div #(
  parameter int unsigned DVD_W = 43,
  parameter int unsigned DVS_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output logic                  done
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] trial;
  logic             fits;

  // The shared subtractor: shifted remainder minus divisor.
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign fits   = !trial[DVS_W+1];

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// ----- src/timed_sample_derivative.sv -----
// Top level of the timed sample derivative: sequencer, state and result register.
`default_nettype none

`include "timed_sample_derivative_assert.svh"

// Backward-difference derivative of timestamped temperature samples. Each input beat
// carries a sample and its timestamp and yields exactly one result beat. With no prior
// sample (stored timestamp zero) the result is a slope of zero with refreshed set, and
// the sample is stored. When the elapsed time, taken modulo 2^32, is zero or below
// min_span, the held slope is returned with refreshed clear and nothing is stored.
// Otherwise the slope is (new - old) * SLOPE_SCALE / elapsed, truncated toward zero and
// saturated to 32 bits signed, and sample, timestamp and slope are stored. The
// temperature difference is read as a 32-bit two's complement value and the elapsed
// time as an unsigned divisor, so a timestamp that went backwards counts as a long
// interval. The block handles one sample at a time: in_chan.ready is high only while
// the sequencer is idle. A sample that computes a fresh slope spends most of its time
// in the radix-2 divider, which retires one quotient bit per cycle through a single
// subtractor on a dividend of PROD_W bits, 32 plus the bit width of SLOPE_SCALE.
// Samples that return the held slope or start a new history skip the multiply and
// divide states. The result sits in an output register, so a stalled result channel
// delays only the hand-over of the next result. min_span is written through cfg_we
// and cfg_wdata, which the user must do only while the block is idle; the block
// itself does not enforce it. min_span resets to 1.
module timed_sample_derivative #(
  parameter int unsigned SLOPE_SCALE = tsd_pkg::SLOPE_SCALE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [tsd_pkg::SPAN_W-1:0] cfg_wdata,
  tsd_in_if.sink                          in_chan,
  tsd_out_if.source                       out_chan
);

  // Width of the scale constant and of the exact product that feeds the divider.
  localparam int unsigned SCALE_W = $clog2(SLOPE_SCALE + 1);
  localparam int unsigned PROD_W  = tsd_pkg::VAL_W + SCALE_W;
  localparam int unsigned SW      = tsd_pkg::SLOPE_W;

  // One-hot sequencer.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CHK  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration and the derivative's history.
  logic [tsd_pkg::SPAN_W-1:0]  min_span_r;
  logic [SW-1:0]               held_slope_r, held_slope_nxt;
  logic [tsd_pkg::VAL_W-1:0]   prior_value_r, prior_value_nxt;
  logic [tsd_pkg::STAMP_W-1:0] prior_stamp_r, prior_stamp_nxt;

  // The sample being worked on and the intermediate values.
  logic [tsd_pkg::VAL_W-1:0]   smp_value_r, smp_value_nxt;
  logic [tsd_pkg::STAMP_W-1:0] smp_stamp_r, smp_stamp_nxt;
  logic [tsd_pkg::STAMP_W-1:0] span_r, span_nxt;
  logic [tsd_pkg::VAL_W-1:0]   mag_r, mag_nxt;
  logic                        neg_r, neg_nxt;

  // Finished result, waiting for the output register.
  logic [SW-1:0] res_slope_r, res_slope_nxt;
  logic          res_refr_r, res_refr_nxt;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_slope_r, out_slope_nxt;
  logic          out_refr_r, out_refr_nxt;

  // Combinational helpers.
  logic [tsd_pkg::STAMP_W-1:0] elapsed;
  logic [tsd_pkg::VAL_W-1:0]   diff;
  logic                        in_fire;
  logic                        out_free;
  logic                        div_start;
  logic [PROD_W-1:0]           div_dividend;
  logic [PROD_W-1:0]           div_quo;
  logic                        div_done;
  logic                        quo_sat;
  logic [SW-1:0]               div_slope;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign elapsed = smp_stamp_r - prior_stamp_r;
  assign diff    = smp_value_r - prior_value_r;

  // The exact product goes straight into the divider's dividend register.
  assign div_start    = (state_r == ST_MUL);
  assign div_dividend = PROD_W'(mag_r) * PROD_W'(SCALE_W'(SLOPE_SCALE));

  tsd_div #(
    .DVD_W (PROD_W),
    .DVS_W (tsd_pkg::STAMP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (span_r),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Any quotient of 2^31 or more saturates, for either sign.
  assign quo_sat = |div_quo[PROD_W-1:SW-1];

  always_comb begin
    if (neg_r) begin
      div_slope = quo_sat ? {1'b1, {(SW-1){1'b0}}} : (~div_quo[SW-1:0] + SW'(1));
    end else begin
      div_slope = quo_sat ? {1'b0, {(SW-1){1'b1}}} : div_quo[SW-1:0];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    held_slope_nxt  = held_slope_r;
    prior_value_nxt = prior_value_r;
    prior_stamp_nxt = prior_stamp_r;
    smp_value_nxt   = smp_value_r;
    smp_stamp_nxt   = smp_stamp_r;
    span_nxt        = span_r;
    mag_nxt         = mag_r;
    neg_nxt         = neg_r;
    res_slope_nxt   = res_slope_r;
    res_refr_nxt    = res_refr_r;
    out_valid_nxt   = out_valid_r;
    out_slope_nxt   = out_slope_r;
    out_refr_nxt    = out_refr_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          smp_value_nxt = in_chan.sample_value;
          smp_stamp_nxt = in_chan.sample_stamp;
          state_nxt     = ST_CHK;
        end
      end
      ST_CHK: begin
        priority if (prior_stamp_r == '0) begin
          // First sample of a history: store it with a zero slope.
          res_slope_nxt   = '0;
          res_refr_nxt    = 1'b1;
          held_slope_nxt  = '0;
          prior_value_nxt = smp_value_r;
          prior_stamp_nxt = smp_stamp_r;
          state_nxt       = ST_OUT;
        end else if (elapsed == '0 || elapsed < {1'b0, min_span_r}) begin
          // Too little time has passed: repeat the held slope.
          res_slope_nxt = held_slope_r;
          res_refr_nxt  = 1'b0;
          state_nxt     = ST_OUT;
        end else begin
          neg_nxt   = diff[tsd_pkg::VAL_W-1];
          mag_nxt   = diff[tsd_pkg::VAL_W-1] ? (~diff + tsd_pkg::VAL_W'(1)) : diff;
          span_nxt  = elapsed;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_slope_nxt   = div_slope;
          res_refr_nxt    = 1'b1;
          held_slope_nxt  = div_slope;
          prior_value_nxt = smp_value_r;
          prior_stamp_nxt = smp_stamp_r;
          state_nxt       = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slope_nxt = res_slope_r;
          out_refr_nxt  = res_refr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      min_span_r    <= tsd_pkg::MIN_SPAN_RST;
      held_slope_r  <= '0;
      prior_value_r <= '0;
      prior_stamp_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      held_slope_r  <= held_slope_nxt;
      prior_value_r <= prior_value_nxt;
      prior_stamp_r <= prior_stamp_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        min_span_r <= cfg_wdata;
      end
    end
    smp_value_r <= smp_value_nxt;
    smp_stamp_r <= smp_stamp_nxt;
    span_r      <= span_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    res_slope_r <= res_slope_nxt;
    res_refr_r  <= res_refr_nxt;
    out_slope_r <= out_slope_nxt;
    out_refr_r  <= out_refr_nxt;
  end

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.slope     = out_slope_r;
  assign out_chan.refreshed = out_refr_r;

  // An accepted sample keeps the block busy for at least the following cycle.
  `TSD_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_chan.ready,
                   "sample accepted on two consecutive cycles")

  // The divider only finishes while the sequencer is waiting for it.
  `TSD_ASSERT_NOW(a_div_done_in_div, div_done, state_r == ST_DIV,
                  "divider finished outside the divide state")

  // A finished result with a free output register is presented on the next cycle.
  `TSD_ASSERT_NEXT(a_result_loaded, (state_r == ST_OUT) && !out_valid_r, out_valid_r,
                   "finished result was not loaded into a free output register")

endmodule

`default_nettype wire
